/* rtl/gadl_pkg.sv */
// gadl_pkg: shared constants and the tangent threshold table for the gradient angle lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gadl_pkg;

    localparam int GRAD_WIDTH_DEF = 16;
    localparam int RATIO_SHIFT    = 10;
    localparam int TAN_BINS       = 90;
    localparam int TAN_W          = 17;
    localparam int IDX_W          = 7;
    localparam int ANGLE_W        = 8;
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO  = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_RIGHT = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF  = 8'd180;

    function automatic logic [TAN_W-1:0] tan_edge(input logic [IDX_W-1:0] k);
        logic [TAN_W-1:0] t;
        case (k)
            7'd0: t = 17'd9;        7'd1: t = 17'd27;       7'd2: t = 17'd45;
            7'd3: t = 17'd63;       7'd4: t = 17'd81;       7'd5: t = 17'd99;
            7'd6: t = 17'd117;      7'd7: t = 17'd135;      7'd8: t = 17'd153;
            7'd9: t = 17'd171;      7'd10: t = 17'd190;     7'd11: t = 17'd208;
            7'd12: t = 17'd227;     7'd13: t = 17'd246;     7'd14: t = 17'd265;
            7'd15: t = 17'd284;     7'd16: t = 17'd303;     7'd17: t = 17'd323;
            7'd18: t = 17'd343;     7'd19: t = 17'd363;     7'd20: t = 17'd383;
            7'd21: t = 17'd403;     7'd22: t = 17'd424;     7'd23: t = 17'd445;
            7'd24: t = 17'd467;     7'd25: t = 17'd488;     7'd26: t = 17'd511;
            7'd27: t = 17'd533;     7'd28: t = 17'd556;     7'd29: t = 17'd579;
            7'd30: t = 17'd603;     7'd31: t = 17'd628;     7'd32: t = 17'd652;
            7'd33: t = 17'd678;     7'd34: t = 17'd704;     7'd35: t = 17'd730;
            7'd36: t = 17'd758;     7'd37: t = 17'd786;     7'd38: t = 17'd815;
            7'd39: t = 17'd844;     7'd40: t = 17'd875;     7'd41: t = 17'd906;
            7'd42: t = 17'd938;     7'd43: t = 17'd972;     7'd44: t = 17'd1006;
            7'd45: t = 17'd1042;    7'd46: t = 17'd1079;    7'd47: t = 17'd1117;
            7'd48: t = 17'd1157;    7'd49: t = 17'd1199;    7'd50: t = 17'd1242;
            7'd51: t = 17'd1287;    7'd52: t = 17'd1335;    7'd53: t = 17'd1384;
            7'd54: t = 17'd1436;    7'd55: t = 17'd1490;    7'd56: t = 17'd1547;
            7'd57: t = 17'd1607;    7'd58: t = 17'd1671;    7'd59: t = 17'd1738;
            7'd60: t = 17'd1810;    7'd61: t = 17'd1886;    7'd62: t = 17'd1967;
            7'd63: t = 17'd2054;    7'd64: t = 17'd2147;    7'd65: t = 17'd2247;
            7'd66: t = 17'd2355;    7'd67: t = 17'd2472;    7'd68: t = 17'd2600;
            7'd69: t = 17'd2739;    7'd70: t = 17'd2892;    7'd71: t = 17'd3060;
            7'd72: t = 17'd3248;    7'd73: t = 17'd3457;    7'd74: t = 17'd3692;
            7'd75: t = 17'd3960;    7'd76: t = 17'd4265;    7'd77: t = 17'd4619;
            7'd78: t = 17'd5033;    7'd79: t = 17'd5525;    7'd80: t = 17'd6119;
            7'd81: t = 17'd6852;    7'd82: t = 17'd7778;    7'd83: t = 17'd8988;
            7'd84: t = 17'd10635;   7'd85: t = 17'd13011;   7'd86: t = 17'd16742;
            7'd87: t = 17'd23453;   7'd88: t = 17'd39105;   7'd89: t = 17'd117339;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

/* rtl/gradient_angle_degrees_lut_top.sv */
// pipeline from input beat to output beat: front stage, 7 search stages, output stage
// throughput: one beat per cycle while the output is not stalled; one table read and one multiply per search stage
// a stall on the output freezes the whole pipeline, nothing is dropped or repeated
// reset: rst_n asynchronous active low clears all valid bits; no other state
// depends on gadl_pkg, gadl_front, gadl_search_stage
`timescale 1ns / 1ps
`default_nettype none
module gradient_angle_degrees_lut_top
    import gadl_pkg::*;
#(
    parameter int GRAD_WIDTH = GRAD_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // grad_y, grad_x, zero pad
    input  wire logic [((2*GRAD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // angle_deg
    output logic [ANGLE_W-1:0]                       m_axis_tdata
);

    localparam int NSTAGE = IDX_W;

    logic en;
    logic [NSTAGE:0]                 v;
    logic [GRAD_WIDTH-1:0]           my [NSTAGE+1];
    logic [GRAD_WIDTH-1:0]           mx [NSTAGE+1];
    logic [NSTAGE:0]                 sd;
    logic [NSTAGE:0]                 yz;
    logic [IDX_W-1:0]                ix [NSTAGE+1];
    logic                            out_valid_reg;
    logic [ANGLE_W-1:0]              angle_reg;
    logic [ANGLE_W-1:0]              angle_next;
    logic [ANGLE_W-1:0]              cnt;

    assign en            = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = en;
    assign ix[0]         = '0;

    gadl_front #(
        .GRAD_WIDTH (GRAD_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .valid_in      (s_axis_tvalid),
        .grad_y        (s_axis_tdata[GRAD_WIDTH-1:0]),
        .grad_x        (s_axis_tdata[2*GRAD_WIDTH-1:GRAD_WIDTH]),
        .valid_reg     (v[0]),
        .mag_y_reg     (my[0]),
        .mag_x_reg     (mx[0]),
        .sign_diff_reg (sd[0]),
        .y_zero_reg    (yz[0])
    );

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_search
        gadl_search_stage #(
            .GRAD_WIDTH (GRAD_WIDTH),
            .BIT_POS    (NSTAGE - 1 - s)
        ) u_stage (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .valid_in      (v[s]),
            .mag_y_in      (my[s]),
            .mag_x_in      (mx[s]),
            .sign_diff_in  (sd[s]),
            .y_zero_in     (yz[s]),
            .idx_in        (ix[s]),
            .valid_reg     (v[s+1]),
            .mag_y_reg     (my[s+1]),
            .mag_x_reg     (mx[s+1]),
            .sign_diff_reg (sd[s+1]),
            .y_zero_reg    (yz[s+1]),
            .idx_reg       (ix[s+1])
        );
    end

    assign cnt = ANGLE_W'(ix[NSTAGE]);

    always_comb
    begin
        if (yz[NSTAGE] || cnt == ANGLE_ZERO)
        begin
            angle_next = ANGLE_ZERO;
        end
        else if (cnt == ANGLE_RIGHT)
        begin
            angle_next = ANGLE_RIGHT;
        end
        else if (sd[NSTAGE])
        begin
            angle_next = ANGLE_HALF - cnt;
        end
        else
        begin
            angle_next = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v[NSTAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = angle_reg;

endmodule
`default_nettype wire

/* rtl/gadl_front.sv */
// gadl_front: first pipeline stage, magnitudes, sign relation and zero flag
// depends on gadl_pkg
`timescale 1ns / 1ps
`default_nettype none
module gadl_front
    import gadl_pkg::*;
#(
    parameter int GRAD_WIDTH = GRAD_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  valid_in,
    input  wire logic [GRAD_WIDTH-1:0] grad_y,
    input  wire logic [GRAD_WIDTH-1:0] grad_x,
    output logic                       valid_reg,
    output logic [GRAD_WIDTH-1:0]      mag_y_reg,
    output logic [GRAD_WIDTH-1:0]      mag_x_reg,
    output logic                       sign_diff_reg,
    output logic                       y_zero_reg
);

    logic [GRAD_WIDTH-1:0] mag_y_next;
    logic [GRAD_WIDTH-1:0] mag_x_next;

    assign mag_y_next = grad_y[GRAD_WIDTH-1] ? (~grad_y + 1'b1) : grad_y;
    assign mag_x_next = grad_x[GRAD_WIDTH-1] ? (~grad_x + 1'b1) : grad_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_y_reg     <= mag_y_next;
            mag_x_reg     <= mag_x_next;
            sign_diff_reg <= grad_y[GRAD_WIDTH-1] ^ grad_x[GRAD_WIDTH-1];
            y_zero_reg    <= (grad_y == '0);
        end
    end

endmodule
`default_nettype wire

/* rtl/gadl_search_stage.sv */
// gadl_search_stage: one step of the pipelined binary search over the tangent table
// depends on gadl_pkg
`timescale 1ns / 1ps
`default_nettype none
module gadl_search_stage
    import gadl_pkg::*;
#(
    parameter int GRAD_WIDTH = GRAD_WIDTH_DEF,
    parameter int BIT_POS    = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  valid_in,
    input  wire logic [GRAD_WIDTH-1:0] mag_y_in,
    input  wire logic [GRAD_WIDTH-1:0] mag_x_in,
    input  wire logic                  sign_diff_in,
    input  wire logic                  y_zero_in,
    input  wire logic [IDX_W-1:0]      idx_in,
    output logic                       valid_reg,
    output logic [GRAD_WIDTH-1:0]      mag_y_reg,
    output logic [GRAD_WIDTH-1:0]      mag_x_reg,
    output logic                       sign_diff_reg,
    output logic                       y_zero_reg,
    output logic [IDX_W-1:0]           idx_reg
);

    localparam int PROD_W = TAN_W + GRAD_WIDTH;
    localparam logic [IDX_W-1:0] STEP = IDX_W'(1 << BIT_POS);
    localparam logic [IDX_W-1:0] BINS = IDX_W'(TAN_BINS);

    logic [IDX_W-1:0]  cand;
    logic [TAN_W-1:0]  thr;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] lhs;
    logic              pass;
    logic [IDX_W-1:0]  idx_next;

    // count >= cand  <=>  mag_y * 1024 >= T[cand-1] * mag_x
    assign cand     = idx_in | STEP;
    assign thr      = tan_edge(cand - 1'b1);
    assign prod     = PROD_W'(thr) * PROD_W'(mag_x_in);
    assign lhs      = PROD_W'({mag_y_in, {RATIO_SHIFT{1'b0}}});
    assign pass     = (cand <= BINS) && (lhs >= prod);
    assign idx_next = pass ? cand : idx_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_y_reg     <= mag_y_in;
            mag_x_reg     <= mag_x_in;
            sign_diff_reg <= sign_diff_in;
            y_zero_reg    <= y_zero_in;
            idx_reg       <= idx_next;
        end
    end

endmodule
`default_nettype wire
